>>> src/lrco_pkg.sv
// ----------------------------------------------------------------------------
// lrco_pkg
// Shared constants, the CORDIC angle table and the stage types of the lidar
// ring/column organizer.
// ----------------------------------------------------------------------------
package lrco_pkg;

    // Defaults for the top-level parameters
    localparam int ROWS_DEF       = 64;
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int COORD_BITS_DEF = 32;

    // Fixed widths of the datapath and of the ports
    localparam int DATA_W  = 64;   // CORDIC x/y, holds 2^59 times the gain
    localparam int TURN_W  = 32;   // angle in units of 2^-32 turn
    localparam int RING_W  = 16;
    localparam int COORD_W = 32;
    localparam int COUNT_W = 13;
    localparam int DEST_W  = 18;
    localparam int ATAN_N  = 28;
    localparam int SCALE_TOP = 60; // coordinates are lifted to 2^60 full scale

    localparam logic [TURN_W-1:0] HALF_TURN = 32'h8000_0000;

    // atan(2^-i) as a fraction of a turn, 2^-32 units
    localparam logic [TURN_W-1:0] ATAN_TURN [ATAN_N] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
        32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2F,
        32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA,
        32'h0000_517D, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051, 32'h0000_0029,
        32'h0000_0014, 32'h0000_000A, 32'h0000_0005
    };

    // One CORDIC vector moving down the chain
    typedef struct packed {
        logic                     v;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic [TURN_W-1:0]        z;
    } t_vec;

    // Status and result of the column/index stages
    typedef struct packed {
        logic              valid;
        logic              busy;
        logic [DEST_W-1:0] dest;
    } t_post;

endpackage

>>> src/lrco_cordic_cell.sv
// ----------------------------------------------------------------------------
// lrco_cordic_cell
// One vectoring CORDIC micro-rotation with a fixed shift, registered.
// ----------------------------------------------------------------------------
module lrco_cordic_cell import lrco_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_vec i_vec,
    output t_vec o_vec
);

    logic                     r_v;
    logic signed [DATA_W-1:0] r_x;
    logic signed [DATA_W-1:0] r_y;
    logic [TURN_W-1:0]        r_z;
    logic signed [DATA_W-1:0] n_x;
    logic signed [DATA_W-1:0] n_y;
    logic [TURN_W-1:0]        n_z;
    logic signed [DATA_W-1:0] xi;
    logic signed [DATA_W-1:0] yi;
    logic signed [DATA_W-1:0] xs;
    logic signed [DATA_W-1:0] ys;

    assign xi = i_vec.x;
    assign yi = i_vec.y;
    assign xs = xi >>> STEP;
    assign ys = yi >>> STEP;

    // rotate toward the x axis: clockwise while y is positive
    always_comb begin
        if (yi > 0) begin
            n_x = xi + ys;
            n_y = yi - xs;
            n_z = i_vec.z + ATAN_TURN[STEP];
        end else begin
            n_x = xi - ys;
            n_y = yi + xs;
            n_z = i_vec.z - ATAN_TURN[STEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_vec.v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_vec.v = r_v;
    assign o_vec.x = r_x;
    assign o_vec.y = r_y;
    assign o_vec.z = r_z;

endmodule

>>> src/lrco_post.sv
// ----------------------------------------------------------------------------
// lrco_post
// Turn fraction to column and row-major slot: rounding, two products,
// column rounding and wrap, final index add.
// ----------------------------------------------------------------------------
module lrco_post import lrco_pkg::*; #(
    parameter int ROWS       = ROWS_DEF,
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic [TURN_W-1:0]                  i_z,
    input  logic                               i_origin,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]     i_width,
    input  logic [$clog2(ROWS)-1:0]            i_row,
    output t_post                              o_post
);

    localparam int WIDTH_W = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W   = $clog2(ROWS);
    localparam int A_W     = ANGLE_BITS + 1;
    localparam int PA_W    = A_W + WIDTH_W;
    localparam int PR_W    = ROW_W + WIDTH_W;

    logic [TURN_W-1:0]  turn;
    logic [TURN_W:0]    a_sum;
    logic [A_W-1:0]     a_frac;
    logic [PA_W:0]      col_sum;
    logic [WIDTH_W:0]   col_raw;
    logic [WIDTH_W-1:0] n_col;
    logic [PR_W:0]      dest_sum;

    logic               r1_v;
    logic [PA_W-1:0]    r1_pa;
    logic [PR_W-1:0]    r1_pr;
    logic               r2_v;
    logic [WIDTH_W-1:0] r2_col;
    logic [PR_W-1:0]    r2_pr;

    // atan2 + half a turn; the origin reads as exactly half a turn
    always_comb begin
        turn   = i_origin ? HALF_TURN : i_z + HALF_TURN;
        a_sum  = {1'b0, turn} + ((TURN_W+1)'(1) << (TURN_W - 1 - ANGLE_BITS));
        a_frac = A_W'(a_sum >> (TURN_W - ANGLE_BITS));
    end

    // round the scaled fraction to a column, wrap the far edge to zero
    always_comb begin
        col_sum = (PA_W+1)'(r1_pa) + ((PA_W+1)'(1) << (ANGLE_BITS - 1));
        col_raw = (WIDTH_W+1)'(col_sum >> ANGLE_BITS);
        if (col_raw >= (WIDTH_W+1)'(i_width)) begin
            n_col = WIDTH_W'(col_raw - (WIDTH_W+1)'(i_width));
        end else begin
            n_col = WIDTH_W'(col_raw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_pa  <= PA_W'(a_frac) * PA_W'(i_width);
        r1_pr  <= PR_W'(i_row) * PR_W'(i_width);
        r2_col <= n_col;
        r2_pr  <= r1_pr;
    end

    assign dest_sum = (PR_W+1)'(r2_pr) + (PR_W+1)'(r2_col);

    assign o_post.valid = r2_v;
    assign o_post.busy  = r1_v | r2_v;
    assign o_post.dest  = DEST_W'(dest_sum);

endmodule

>>> src/lidar_ring_column_organizer_core.sv
// ----------------------------------------------------------------------------
// lidar_ring_column_organizer_core
// Count pass: ring-half flag machine that counts image columns.
// Scatter pass: CORDIC azimuth to column and row-major range-image slot.
// ----------------------------------------------------------------------------
// Path: a count beat, or a scatter beat with a bad ring or zero width, goes
//   straight to the hold stage; a good scatter beat first passes the entry
//   stage, the CORDIC cells and the two index stages. Hold feeds the output.
// Flow: one beat in flight; the next beat is taken once the previous one has
//   left the hold stage, which a stalled output can delay. The chain holds
//   ANGLE_BITS+4 CORDIC cells (at most ATAN_N) after the entry stage.
// Reset (synchronous, active low) clears the column counter, both half flags
//   and every valid bit; no clearing pass.
// ----------------------------------------------------------------------------
module lidar_ring_column_organizer_core import lrco_pkg::*; #(
    parameter int ROWS       = ROWS_DEF,
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input beats
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_kind,
    input  logic                      i_start_of_cloud,
    input  logic [RING_W-1:0]         i_ring,
    input  logic signed [COORD_W-1:0] i_x,
    input  logic signed [COORD_W-1:0] i_y,
    // result beats
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [COUNT_W-1:0]        o_column_count,
    output logic [DEST_W-1:0]         o_dest_index,
    output logic                      o_index_valid,
    output logic                      o_ring_error
);

    localparam int WIDTH_W = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W   = $clog2(ROWS);
    localparam int STEPS   = (ANGLE_BITS + 4 < ATAN_N) ? ANGLE_BITS + 4 : ATAN_N;
    localparam int SCALE   = SCALE_TOP - COORD_BITS;

    // ---------------------------------------------------------------- accept
    logic in_acc;
    logic busy;
    logic ring_bad;
    logic ring_up;
    logic scatter_go;

    assign in_acc   = i_in_valid & ~o_in_stall;
    assign ring_bad = i_ring > RING_W'(ROWS - 1);
    assign ring_up  = i_ring >= RING_W'(ROWS / 2);

    // ------------------------------------------------- count-pass flag machine
    logic [WIDTH_W-1:0] r_counter;
    logic [WIDTH_W-1:0] n_counter;
    logic               r_in_upper;
    logic               n_in_upper;
    logic               r_started;
    logic               n_started;
    logic               bump;

    // A column closes when the rings come back to the half the scan began in.
    always_comb begin
        n_counter  = r_counter;
        n_in_upper = r_in_upper;
        n_started  = r_started;
        bump       = (~ring_up & r_in_upper & ~r_started) |
                     (ring_up & ~r_in_upper & r_started);
        if (i_start_of_cloud) begin
            n_in_upper = ring_up;
            n_started  = ring_up;
            n_counter  = WIDTH_W'(1);
        end else begin
            n_in_upper = ring_up;
            if (bump && r_counter < WIDTH_W'(MAX_WIDTH)) begin
                n_counter = r_counter + WIDTH_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter  <= '0;
            r_in_upper <= 1'b0;
            r_started  <= 1'b0;
        end else if (in_acc && !i_kind) begin
            r_counter  <= n_counter;
            r_in_upper <= n_in_upper;
            r_started  <= n_started;
        end
    end

    // Scatter beats only go through the CORDIC with a good ring and a width.
    assign scatter_go = in_acc & i_kind & ~ring_bad & (r_counter != '0);

    // ------------------------------------------------------------ entry stage
    logic signed [DATA_W-1:0] sx;
    logic signed [DATA_W-1:0] sy;
    logic signed [DATA_W-1:0] n_ent_x;
    logic signed [DATA_W-1:0] n_ent_y;
    logic [TURN_W-1:0]        n_ent_z;
    logic                     left_half;
    logic                     r_ent_v;
    logic signed [DATA_W-1:0] r_ent_x;
    logic signed [DATA_W-1:0] r_ent_y;
    logic [TURN_W-1:0]        r_ent_z;
    logic                     r_origin;
    logic [ROW_W-1:0]         r_row;

    // Take the low coordinate bits as two's complement, fold the left
    // half-plane by half a turn, then lift to the CORDIC scale.
    always_comb begin
        sx        = {{(DATA_W-COORD_BITS){i_x[COORD_BITS-1]}}, i_x[COORD_BITS-1:0]};
        sy        = {{(DATA_W-COORD_BITS){i_y[COORD_BITS-1]}}, i_y[COORD_BITS-1:0]};
        left_half = sx < 0;
        n_ent_x   = (left_half ? -sx : sx) <<< SCALE;
        n_ent_y   = (left_half ? -sy : sy) <<< SCALE;
        n_ent_z   = left_half ? HALF_TURN : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_v <= 1'b0;
        end else begin
            r_ent_v <= scatter_go;
        end
    end

    // Side registers stay put while the beat is in flight: one beat at a time.
    always_ff @(posedge i_clk) begin
        r_ent_x <= n_ent_x;
        r_ent_y <= n_ent_y;
        r_ent_z <= n_ent_z;
        if (scatter_go) begin
            r_origin <= (sx == '0) && (sy == '0);
            r_row    <= ROW_W'(ROWS - 1) - i_ring[ROW_W-1:0];
        end
    end

    // ---------------------------------------------------------- CORDIC chain
    t_vec chain [STEPS+1];
    logic chain_busy;

    assign chain[0].v = r_ent_v;
    assign chain[0].x = r_ent_x;
    assign chain[0].y = r_ent_y;
    assign chain[0].z = r_ent_z;

    for (genvar k = 0; k < STEPS; k++) begin : g_cell
        lrco_cordic_cell #(
            .STEP (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vec   (chain[k]),
            .o_vec   (chain[k+1])
        );
    end

    always_comb begin
        chain_busy = 1'b0;
        for (int k = 0; k <= STEPS; k++) begin
            chain_busy = chain_busy | chain[k].v;
        end
    end

    // ------------------------------------------------------ column and index
    t_post post;

    lrco_post #(
        .ROWS       (ROWS),
        .MAX_WIDTH  (MAX_WIDTH),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (chain[STEPS].v),
        .i_z      (chain[STEPS].z),
        .i_origin (r_origin),
        .i_width  (r_counter),
        .i_row    (r_row),
        .o_post   (post)
    );

    // ----------------------------------------------------------- hold stage
    // Finished beats park here so the output register can stall freely.
    logic               r_hold_v;
    logic [COUNT_W-1:0] r_hold_cnt;
    logic [DEST_W-1:0]  r_hold_dest;
    logic               r_hold_iv;
    logic               r_hold_err;
    logic               direct;
    logic               hold_take;

    assign direct    = in_acc & ~scatter_go;
    assign hold_take = r_hold_v & (~o_out_valid | ~i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
        end else if (direct || post.valid) begin
            r_hold_v <= 1'b1;
        end else if (hold_take) begin
            r_hold_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (direct) begin
            r_hold_cnt  <= COUNT_W'(i_kind ? r_counter : n_counter);
            r_hold_dest <= '0;
            r_hold_iv   <= 1'b0;
            r_hold_err  <= ring_bad;
        end else if (post.valid) begin
            r_hold_cnt  <= COUNT_W'(r_counter);
            r_hold_dest <= post.dest;
            r_hold_iv   <= 1'b1;
            r_hold_err  <= 1'b0;
        end
    end

    // ------------------------------------------------------- output register
    logic r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (hold_take) begin
            r_out_v <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hold_take) begin
            o_column_count <= r_hold_cnt;
            o_dest_index   <= r_hold_dest;
            o_index_valid  <= r_hold_iv;
            o_ring_error   <= r_hold_err;
        end
    end

    assign o_out_valid = r_out_v;

    // Take a new beat only once the previous one has left the hold stage.
    assign busy       = chain_busy | post.busy | r_hold_v;
    assign o_in_stall = busy;

endmodule

>>> src/lrco_checker.sv
// ----------------------------------------------------------------------------
// lrco_checker
// Port-level checks of the organizer, bound to the top level.
// ----------------------------------------------------------------------------
module lrco_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [12:0] o_column_count,
    input logic [17:0] o_dest_index,
    input logic        o_index_valid,
    input logic        o_ring_error
);

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // one beat at a time: an accepted beat blocks the next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a beat is in flight");

    // a placed point never carries a ring error
    a_valid_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_index_valid && o_ring_error))
        else $error("index valid together with ring error");

    // unplaced points report slot zero
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_index_valid) |-> (o_dest_index == 18'd0))
        else $error("nonzero index on an unplaced point");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_dest_index) && $stable(o_column_count)))
        else $error("stalled result changed");

endmodule

bind lidar_ring_column_organizer_core lrco_checker u_lrco_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_column_count (o_column_count),
    .o_dest_index   (o_dest_index),
    .o_index_valid  (o_index_valid),
    .o_ring_error   (o_ring_error)
);

>>> dv/tb_lidar_ring_column_organizer_core.sv
// ----------------------------------------------------------------------------
// tb_lidar_ring_column_organizer_core
// Self-checking bench for the lidar ring/column organizer. A bit-true model of
// the ring-half column counter and of the CORDIC azimuth-to-slot mapping
// predicts every result beat. Directed corner cases come first. Random clouds
// follow under changing idle patterns, with one long output hold-off. A final
// sweep grows the column count at full rate.
// ----------------------------------------------------------------------------
module tb_lidar_ring_column_organizer_core;

    timeunit 1ns;
    timeprecision 1ps;

    import lrco_pkg::*;

    // Block configuration seen by the bench (the DUT runs at its defaults)
    localparam int IMG_ROWS      = ROWS_DEF;
    localparam int IMG_MAX_WIDTH = MAX_WIDTH_DEF;
    localparam int AZ_BITS       = ANGLE_BITS_DEF;
    localparam int XY_BITS       = COORD_BITS_DEF;
    localparam int CORDIC_ITERS  = AZ_BITS + 4;

    // Beat kinds
    localparam logic KIND_COUNT   = 1'b0;
    localparam logic KIND_SCATTER = 1'b1;

    // Run guards
    localparam int CYCLE_LIMIT = 500_000;
    localparam int TAIL_CYCLES = AZ_BITS + 40;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ATAN_STEP [28] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
        32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2F,
        32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA,
        32'h0000_517D, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051, 32'h0000_0029,
        32'h0000_0014, 32'h0000_000A, 32'h0000_0005
    };

    typedef struct packed {
        logic                      kind;
        logic                      start;
        logic [RING_W-1:0]         ring;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_point;

    typedef struct packed {
        logic [COUNT_W-1:0] column_count;
        logic [DEST_W-1:0]  dest_index;
        logic               index_valid;
        logic               ring_error;
    } t_slot;

    // DUT ports
    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic                      i_kind;
    logic                      i_start_of_cloud;
    logic [RING_W-1:0]         i_ring;
    logic signed [COORD_W-1:0] i_x;
    logic signed [COORD_W-1:0] i_y;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic [COUNT_W-1:0]        o_column_count;
    logic [DEST_W-1:0]         o_dest_index;
    logic                      o_index_valid;
    logic                      o_ring_error;

    // Shadow state of the column counter machine
    logic [COUNT_W-1:0] shadow_columns;
    logic               shadow_in_upper;
    logic               shadow_started_upper;

    // Slots predicted for accepted beats, oldest first
    t_slot expected_slots [$];

    int error_count     = 0;
    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int holdoff_request = 0;
    int holdoff_left    = 0;

    lidar_ring_column_organizer_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_start_of_cloud (i_start_of_cloud),
        .i_ring           (i_ring),
        .i_x              (i_x),
        .i_y              (i_y),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_column_count   (o_column_count),
        .o_dest_index     (o_dest_index),
        .o_index_valid    (o_index_valid),
        .o_ring_error     (o_ring_error)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Azimuth as atan2(y,x)/(2*pi) + 0.5 in units of 2^-32 turn, modulo one turn.
    function automatic logic [31:0] azimuth_turn(input longint px, input longint py);
        longint      vx;
        longint      vy;
        longint      sx;
        longint      sy;
        logic [31:0] acc;
        int          i;
        // the origin maps to atan2 = 0
        if (px == 0 && py == 0) return HALF_TURN;
        vx  = px;
        vy  = py;
        acc = '0;
        // fold the left half-plane over by half a turn
        if (vx < 0) begin
            vx  = -vx;
            vy  = -vy;
            acc = HALF_TURN;
        end
        vx = vx * (64'sd1 <<< (60 - XY_BITS));
        vy = vy * (64'sd1 <<< (60 - XY_BITS));
        for (i = 0; i < CORDIC_ITERS && i < 28; i++) begin
            sx = vx >>> i;
            sy = vy >>> i;
            if (vy > 0) begin
                vx  = vx + sy;
                vy  = vy - sx;
                acc = acc + ATAN_STEP[i];
            end else begin
                vx  = vx - sy;
                vy  = vy + sx;
                acc = acc - ATAN_STEP[i];
            end
        end
        return acc + HALF_TURN;
    endfunction

    // Advance the shadow counter for one beat and return the slot it yields.
    function automatic t_slot predict_slot(input t_point p);
        t_slot           s;
        logic            upper;
        logic            bad;
        logic            bump;
        logic [31:0]     turn;
        longint unsigned w;
        longint unsigned frac;
        longint unsigned col;
        longint unsigned dest;
        bad   = p.ring > RING_W'(IMG_ROWS - 1);
        upper = p.ring >= RING_W'(IMG_ROWS / 2);
        dest  = 0;
        s     = '0;
        if (p.kind == KIND_COUNT) begin
            if (p.start) begin
                // restart the scan: remember the half it begins in
                shadow_in_upper      = upper;
                shadow_started_upper = upper;
                shadow_columns       = 1;
            end else begin
                // count a column on each return to the starting half
                bump = (!upper && shadow_in_upper && !shadow_started_upper) ||
                       (upper && !shadow_in_upper && shadow_started_upper);
                if (bump && shadow_columns < COUNT_W'(IMG_MAX_WIDTH))
                    shadow_columns = shadow_columns + 1'b1;
                shadow_in_upper = upper;
            end
        end else if (!bad && shadow_columns != 0) begin
            turn = azimuth_turn(longint'($signed(p.x[XY_BITS-1:0])),
                                longint'($signed(p.y[XY_BITS-1:0])));
            w    = longint'(shadow_columns);
            frac = (longint'(turn) + (64'd1 << (31 - AZ_BITS))) >> (32 - AZ_BITS);
            col  = (frac * w + (64'd1 << (AZ_BITS - 1))) >> AZ_BITS;
            // a column at the right edge wraps to the left edge
            if (col >= w) col = col - w;
            dest = longint'(IMG_ROWS - 1 - int'(p.ring)) * w + col;
            s.dest_index  = DEST_W'(dest);
            s.index_valid = 1'b1;
        end
        s.column_count = shadow_columns;
        s.ring_error   = bad;
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(4))
            0: return 32'($urandom);
            1: return 32'($signed($urandom_range(40)) - 20);
            2: begin
                case ($urandom_range(3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7FFF_FFFF;
                    2: return 32'sh0000_0000;
                    default: return -32'sd1;
                endcase
            end
            default: return $signed($urandom) >>> $urandom_range(31);
        endcase
    endfunction

    // Ring in the requested half, now and then any 16-bit value
    function automatic logic [RING_W-1:0] pick_ring(input logic upper);
        if ($urandom_range(99) < 4) return RING_W'($urandom);
        if (upper) return RING_W'(IMG_ROWS / 2 + $urandom_range(IMG_ROWS / 2 - 1));
        return RING_W'($urandom_range(IMG_ROWS / 2 - 1));
    endfunction

    // Offer one beat, hold it until accepted, then log its predicted slot.
    // Valid stays high on return so back-to-back beats need no extra edge.
    task automatic send_point(input logic kind, input logic start,
                              input logic [RING_W-1:0] ring,
                              input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y);
        t_point p;
        p = '{kind, start, ring, x, y};
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid       <= 1'b1;
        i_kind           <= kind;
        i_start_of_cloud <= start;
        i_ring           <= ring;
        i_x              <= x;
        i_y              <= y;
        do @(posedge i_clk); while (o_in_stall);
        expected_slots.push_back(predict_slot(p));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Scatter right after reset: no width counted yet
    task automatic test_zero_width_scatter();
        send_point(KIND_SCATTER, 1'b0, 16'd5, 32'sd100, 32'sd100);
    endtask

    // Count beats with no start point: flags read as a lower-half scan
    task automatic test_count_without_start();
        send_point(KIND_COUNT, 1'b0, 16'd40, 32'sd0, 32'sd0);
        send_point(KIND_COUNT, 1'b0, 16'd10, 32'sd0, 32'sd0);
        send_point(KIND_COUNT, 1'b0, 16'd50, 32'sd0, 32'sd0);
        send_point(KIND_COUNT, 1'b0, 16'd5,  32'sd0, 32'sd0);
    endtask

    // Scan from the lower half, ring boundaries, then coordinate extremes
    task automatic test_lower_start_extremes();
        send_point(KIND_COUNT,   1'b1, 16'd0,  32'sd0, 32'sd0);
        send_point(KIND_COUNT,   1'b0, 16'd63, 32'sd0, 32'sd0);
        send_point(KIND_COUNT,   1'b0, 16'd31, 32'sd0, 32'sd0);
        send_point(KIND_COUNT,   1'b0, 16'd32, 32'sd0, 32'sd0);
        send_point(KIND_COUNT,   1'b0, 16'd0,  32'sd0, 32'sd0);
        // origin, left axis, just below the right axis, just above the left axis
        send_point(KIND_SCATTER, 1'b0, 16'd0,  32'sd0, 32'sd0);
        send_point(KIND_SCATTER, 1'b1, 16'd63, 32'sh8000_0000, 32'sd0);
        send_point(KIND_SCATTER, 1'b0, 16'd31, 32'sh7FFF_FFFF, -32'sd1);
        send_point(KIND_SCATTER, 1'b0, 16'd32, 32'sh8000_0000, 32'sd1);
        send_point(KIND_SCATTER, 1'b0, 16'd0,  32'sd0, 32'sh7FFF_FFFF);
        send_point(KIND_SCATTER, 1'b0, 16'd63, -32'sd1, 32'sd1);
    endtask

    // Scan from the upper half: columns count on returns to the upper half
    task automatic test_upper_start();
        send_point(KIND_COUNT,   1'b1, 16'd32, 32'sd0, 32'sd0);
        send_point(KIND_COUNT,   1'b0, 16'd31, 32'sd0, 32'sd0);
        send_point(KIND_COUNT,   1'b0, 16'd63, 32'sd0, 32'sd0);
        send_point(KIND_COUNT,   1'b0, 16'd0,  32'sd0, 32'sd0);
        send_point(KIND_COUNT,   1'b0, 16'd40, 32'sd0, 32'sd0);
        send_point(KIND_SCATTER, 1'b0, 16'd10, 32'sd5, -32'sd7);
    endtask

    // Out-of-range rings in both passes; in the count pass they act as upper half
    task automatic test_bad_rings();
        send_point(KIND_COUNT,   1'b0, 16'd64,    32'sd0, 32'sd0);
        send_point(KIND_COUNT,   1'b0, 16'hFFFF,  32'sd0, 32'sd0);
        send_point(KIND_COUNT,   1'b0, 16'd0,     32'sd0, 32'sd0);
        send_point(KIND_SCATTER, 1'b0, 16'd64,    32'sd3, 32'sd4);
        send_point(KIND_SCATTER, 1'b1, 16'hFFFF,  -32'sd9, 32'sd2);
    endtask

    // Hold the result side off for a long stretch while beats keep coming,
    // so the block fills and stalls its input
    task automatic test_output_holdoff();
        int k;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        holdoff_request = 250;
        send_point(KIND_COUNT, 1'b1, pick_ring(1'b0), rand_coord(), rand_coord());
        for (k = 0; k < 15; k++) begin
            if (k[0])
                send_point(KIND_SCATTER, 1'b0, pick_ring(k[1]), rand_coord(), rand_coord());
            else
                send_point(KIND_COUNT, 1'b0, pick_ring(k[1]), rand_coord(), rand_coord());
        end
    endtask

    // Well-formed clouds with random content, mixed with raw noise beats
    task automatic test_random_clouds(input int n_items);
        int   sent;
        int   n_count;
        int   n_scatter;
        int   k;
        logic upper;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 10) begin
                send_point(1'($urandom), 1'($urandom), RING_W'($urandom),
                           32'($urandom), 32'($urandom));
                sent++;
            end else begin
                upper = 1'($urandom);
                send_point(KIND_COUNT, 1'b1, pick_ring(upper), rand_coord(), rand_coord());
                n_count = $urandom_range(1, 24);
                for (k = 0; k < n_count; k++) begin
                    if ($urandom_range(99) < 45) upper = !upper;
                    // a stray start now and then restarts the count mid-scan
                    send_point(KIND_COUNT, $urandom_range(99) < 3, pick_ring(upper),
                               rand_coord(), rand_coord());
                end
                n_scatter = $urandom_range(1, 16);
                for (k = 0; k < n_scatter; k++)
                    send_point(KIND_SCATTER, 1'($urandom), pick_ring(1'($urandom)),
                               rand_coord(), rand_coord());
                sent += 1 + n_count + n_scatter;
            end
        end
    endtask

    // Sweep halves back to back to grow the width, then scatter on the
    // top and bottom rows
    task automatic test_width_sweep();
        int k;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_point(KIND_COUNT, 1'b1, 16'd0, rand_coord(), rand_coord());
        for (k = 0; k < 40; k++) begin
            send_point(KIND_COUNT, 1'b0, RING_W'(32 + $urandom_range(31)),
                       rand_coord(), rand_coord());
            send_point(KIND_COUNT, 1'b0, RING_W'($urandom_range(31)),
                       rand_coord(), rand_coord());
        end
        for (k = 0; k < 12; k++)
            send_point(KIND_SCATTER, 1'b0, k[0] ? 16'd0 : 16'd63, rand_coord(), rand_coord());
    endtask

    // ------------------------------------------------------------------------
    // Result side: check each accepted beat, then drive the next stall
    // ------------------------------------------------------------------------
    initial begin : result_checker
        t_slot got;
        t_slot want;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got = '{o_column_count, o_dest_index, o_index_valid, o_ring_error};
                if (expected_slots.size() == 0) begin
                    $error("unexpected result beat: column_count %0d dest_index %0d",
                           got.column_count, got.dest_index);
                    error_count++;
                end else begin
                    want = expected_slots.pop_front();
                    if (got.column_count != want.column_count) begin
                        $error("column_count mismatch: expected %0d, actual %0d",
                               want.column_count, got.column_count);
                        error_count++;
                    end
                    if (got.dest_index != want.dest_index) begin
                        $error("dest_index mismatch: expected %0d, actual %0d",
                               want.dest_index, got.dest_index);
                        error_count++;
                    end
                    if (got.index_valid != want.index_valid) begin
                        $error("index_valid mismatch: expected %0d, actual %0d",
                               want.index_valid, got.index_valid);
                        error_count++;
                    end
                    if (got.ring_error != want.ring_error) begin
                        $error("ring_error mismatch: expected %0d, actual %0d",
                               want.ring_error, got.ring_error);
                        error_count++;
                    end
                end
            end
            // a requested hold-off is counted down here, cycle by cycle
            if (holdoff_request != 0) begin
                holdoff_left    = holdoff_request;
                holdoff_request = 0;
            end
            if (holdoff_left != 0) begin
                i_out_stall <= 1'b1;
                holdoff_left--;
            end else begin
                i_out_stall <= $urandom_range(99) < recv_idle_pct;
            end
        end
    end

    // Watchdog: end the run if it overruns the cycle budget
    initial begin : watchdog
        int cycles;
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
            @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : test_sequence
        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_kind           <= KIND_COUNT;
        i_start_of_cloud <= 1'b0;
        i_ring           <= '0;
        i_x              <= '0;
        i_y              <= '0;
        shadow_columns       = '0;
        shadow_in_upper      = 1'b0;
        shadow_started_upper = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender idles often-ish, receiver stalls most of the time
        send_idle_pct = 27;
        recv_idle_pct = 77;
        test_zero_width_scatter();
        test_count_without_start();
        test_lower_start_extremes();
        test_upper_start();
        test_bad_rings();
        test_random_clouds(260);

        // swap the pressure: sparse sender, mostly ready receiver
        send_idle_pct = 77;
        recv_idle_pct = 27;
        test_random_clouds(260);

        test_output_holdoff();

        // full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_clouds(260);

        test_width_sweep();

        // drain: drop valid, wait for every predicted slot, then let the pipe settle
        i_in_valid <= 1'b0;
        while (expected_slots.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> lidar_ring_column_organizer_core.f
src/lrco_pkg.sv
src/lrco_cordic_cell.sv
src/lrco_post.sv
src/lidar_ring_column_organizer_core.sv
src/lrco_checker.sv
dv/tb_lidar_ring_column_organizer_core.sv
